>>> hdl/xsrng_pkg.sv
// Shared types and constants of the five-word xorshift random number generator.
package xsrng_pkg;

  // Data path widths
  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  // Command queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // Seed conditioning and expansion
  localparam logic [HalfW:0] SeedOffset  = 33'h0_ffff_fffe;
  localparam logic [HalfW:0] SeedModulus = 33'h0_ffff_ffff;
  localparam logic [HalfW:0] SeedMult    = 33'h1_1edc_6f41;
  localparam int unsigned    NumSquares  = 4;

  // Xorshift shift amounts
  localparam int unsigned ShiftA = 7;
  localparam int unsigned ShiftB = 6;
  localparam int unsigned ShiftC = 13;

  // Action codes on the input channel
  typedef enum logic [1:0] {
    ACT_RESEED = 2'd0,
    ACT_RAW    = 2'd1,
    ACT_RANGED = 2'd2,
    ACT_IGNORE = 2'd3
  } action_e;

  // Classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_RESEED    = 3'd0,
    CMD_RAW       = 3'd1,
    CMD_RANGED    = 3'd2,
    CMD_BAD_RANGE = 3'd3,
    CMD_IGNORE    = 3'd4
  } cmd_e;

  // One queued transaction
  typedef struct packed {
    cmd_e             cmd;
    logic [HalfW-1:0] seed;   // conditioned seed, 1 .. 2^32-1
    logic [HalfW-1:0] lower;  // lower bound of a ranged draw
    logic [HalfW-1:0] span;   // upper - lower, valid for ranged draws
  } item_t;

endpackage

>>> hdl/xsrng_fifo.sv
// Short command queue between the classifying front and the executing back.
module xsrng_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xsrng_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output xsrng_pkg::item_t item_o,
  output logic             empty_o
);
  import xsrng_pkg::*;

  item_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]    count_q, count_d;

  assign full_o  = (count_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> hdl/xsrng_front.sv
// Front end: accepts input transactions, classifies them and precomputes operands.
module xsrng_front (
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic [31:0]             seed_value_i,
  input  logic signed [31:0]      lower_i,
  input  logic signed [31:0]      upper_i,
  input  logic                    full_i,
  output logic                    push_o,
  output xsrng_pkg::item_t        item_o
);
  import xsrng_pkg::*;

  logic [HalfW:0] seed_sum;
  logic [HalfW:0] seed_red;
  logic [HalfW:0] span_w;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Seed conditioning: ((seed - 1) mod (2^32 - 1)) + 1, one compare and subtract
  always_comb begin
    seed_sum = {1'b0, seed_value_i} + SeedOffset;
    seed_red = (seed_sum >= SeedModulus) ? (seed_sum - SeedModulus) : seed_sum;
  end

  // Range width at full precision; fits 32 bits whenever lower < upper
  assign span_w = {upper_i[HalfW-1], upper_i} - {lower_i[HalfW-1], lower_i};

  // Classification
  always_comb begin
    item_o.seed  = seed_red[HalfW-1:0] + 32'd1;
    item_o.lower = lower_i;
    item_o.span  = span_w[HalfW-1:0];
    unique case (action_i)
      ACT_RESEED: item_o.cmd = CMD_RESEED;
      ACT_RAW:    item_o.cmd = CMD_RAW;
      ACT_RANGED: item_o.cmd = (lower_i < upper_i) ? CMD_RANGED : CMD_BAD_RANGE;
      ACT_IGNORE: item_o.cmd = CMD_IGNORE;
      default:    item_o.cmd = CMD_IGNORE;
    endcase
  end

endmodule

>>> hdl/xsrng_back.sv
// Back end: generator state, shared 32x32 multiplier, remainder unit and result register.
module xsrng_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  xsrng_pkg::item_t   item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               status_o
);
  import xsrng_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RS_MUL   = 4'd1;
  localparam logic [3:0] ST_RS_X     = 4'd2;
  localparam logic [3:0] ST_SQ_LL    = 4'd3;
  localparam logic [3:0] ST_SQ_LH    = 4'd4;
  localparam logic [3:0] ST_SQ_WR    = 4'd5;
  localparam logic [3:0] ST_DRAW_MUL = 4'd6;
  localparam logic [3:0] ST_DIV      = 4'd7;
  localparam logic [3:0] ST_RG_FIN   = 4'd8;

  localparam int unsigned SqCntW  = $clog2(NumSquares);
  localparam int unsigned DivCntW = $clog2(HalfW);
  localparam logic [SqCntW-1:0]  SqLast  = SqCntW'(NumSquares - 1);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(HalfW - 1);

  logic [3:0]         state_q, state_d;
  logic [WordW-1:0]   x_q, x_d, y_q, y_d, z_q, z_d, w_q, w_d, v_q, v_d;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [WordW-1:0]   prod_q, prod_d;
  logic [HalfW-1:0]   cross_q, cross_d;
  logic [SqCntW-1:0]  sq_cnt_q, sq_cnt_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [HalfW-1:0]   rem_q, rem_d;
  logic [HalfW-1:0]   dvd_q, dvd_d;
  logic               neg_q, neg_d;
  cmd_e               cmd_q, cmd_d;
  logic [HalfW-1:0]   seed_q, seed_d;
  logic [HalfW-1:0]   lower_q, lower_d;
  logic [HalfW-1:0]   span_q, span_d;

  logic               out_valid_q;
  logic [HalfW-1:0]   out_value_q;
  logic               out_status_q;
  logic               out_free;
  logic               out_load;
  logic [HalfW-1:0]   load_value;
  logic               load_status;

  logic [HalfW-1:0]   mul_a, mul_b;
  logic [WordW-1:0]   mul_p;
  logic [WordW-1:0]   t_w, v_next, x_seed, sq_w;
  logic [HalfW:0]     trial;
  logic [HalfW-1:0]   draw_w, fmod_w;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_RS_MUL: begin
        mul_a = seed_q;
        mul_b = SeedMult[HalfW-1:0];
      end
      ST_SQ_LL: begin
        mul_a = acc_q[HalfW-1:0];
        mul_b = acc_q[HalfW-1:0];
      end
      ST_SQ_LH: begin
        mul_a = acc_q[HalfW-1:0];
        mul_b = acc_q[WordW-1:HalfW];
      end
      ST_DRAW_MUL: begin
        mul_a = {y_q[HalfW-2:0], 1'b1};
        mul_b = v_q[HalfW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Xorshift step, arithmetic shift on x
  assign t_w    = x_q ^ {{ShiftA{x_q[WordW-1]}}, x_q[WordW-1:ShiftA]};
  assign v_next = v_q ^ (v_q << ShiftB) ^ t_w ^ (t_w << ShiftC);

  // Seed expansion: s * C with C = 2^32 + low word, squares from two partial products
  assign x_seed = prod_q + {seed_q, {HalfW{1'b0}}};
  assign sq_w   = prod_q + {cross_q[HalfW-2:0], 1'b0, {HalfW{1'b0}}};

  // Output word of a draw and restoring remainder step
  assign draw_w = mul_p[HalfW-1:0];
  assign trial  = {rem_q, dvd_q[HalfW-1]};
  assign fmod_w = (neg_q && (rem_q != '0)) ? (span_q - rem_q) : rem_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    w_d         = w_q;
    v_d         = v_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    cross_d     = cross_q;
    sq_cnt_d    = sq_cnt_q;
    div_cnt_d   = div_cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    neg_d       = neg_q;
    cmd_d       = cmd_q;
    seed_d      = seed_q;
    lower_d     = lower_q;
    span_d      = span_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    load_value  = '0;
    load_status = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          unique case (item_i.cmd)
            CMD_RESEED: begin
              pop_o   = 1'b1;
              seed_d  = item_i.seed;
              state_d = ST_RS_MUL;
            end
            CMD_RAW, CMD_RANGED: begin
              pop_o   = 1'b1;
              cmd_d   = item_i.cmd;
              lower_d = item_i.lower;
              span_d  = item_i.span;
              x_d     = y_q;
              y_d     = z_q;
              z_d     = w_q;
              w_d     = v_q;
              v_d     = v_next;
              state_d = ST_DRAW_MUL;
            end
            default: begin
              // bad range or ignored action: no state change
              if (out_free) begin
                pop_o       = 1'b1;
                out_load    = 1'b1;
                load_status = (item_i.cmd == CMD_BAD_RANGE);
              end
            end
          endcase
        end
      end
      ST_RS_MUL: begin
        prod_d  = mul_p;
        state_d = ST_RS_X;
      end
      ST_RS_X: begin
        x_d      = x_seed;
        acc_d    = x_seed;
        sq_cnt_d = '0;
        state_d  = ST_SQ_LL;
      end
      ST_SQ_LL: begin
        prod_d  = mul_p;
        state_d = ST_SQ_LH;
      end
      ST_SQ_LH: begin
        cross_d = mul_p[HalfW-1:0];
        state_d = ST_SQ_WR;
      end
      ST_SQ_WR: begin
        if ((sq_cnt_q != SqLast) || out_free) begin
          acc_d = sq_w;
          case (sq_cnt_q)
            2'd0:    y_d = sq_w;
            2'd1:    z_d = sq_w;
            2'd2:    w_d = sq_w;
            default: v_d = sq_w;
          endcase
          if (sq_cnt_q == SqLast) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            sq_cnt_d = sq_cnt_q + 1'b1;
            state_d  = ST_SQ_LL;
          end
        end
      end
      ST_DRAW_MUL: begin
        if (cmd_q == CMD_RAW) begin
          if (out_free) begin
            out_load   = 1'b1;
            load_value = draw_w;
            state_d    = ST_IDLE;
          end
        end else begin
          neg_d     = draw_w[HalfW-1];
          dvd_d     = draw_w[HalfW-1] ? (~draw_w + 1'b1) : draw_w;
          rem_d     = '0;
          div_cnt_d = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, only the remainder is kept
        rem_d = (trial >= {1'b0, span_q}) ? (trial[HalfW-1:0] - span_q) : trial[HalfW-1:0];
        dvd_d = {dvd_q[HalfW-2:0], 1'b0};
        if (div_cnt_q == DivLast) begin
          state_d = ST_RG_FIN;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      ST_RG_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_value = lower_q + fmod_w;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      w_q         <= '0;
      v_q         <= '0;
      sq_cnt_q    <= '0;
      div_cnt_q   <= '0;
      cmd_q       <= CMD_IGNORE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      z_q         <= z_d;
      w_q         <= w_d;
      v_q         <= v_d;
      sq_cnt_q    <= sq_cnt_d;
      div_cnt_q   <= div_cnt_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // Data path registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    cross_q <= cross_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    neg_q   <= neg_d;
    seed_q  <= seed_d;
    lower_q <= lower_d;
    span_q  <= span_d;
    if (out_load) begin
      out_value_q  <= load_value;
      out_status_q <= load_status;
    end
  end

  // Checks
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("queue popped while empty");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < span_q))
    else $error("partial remainder not below range width");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_value_q == '0))
    else $error("error result carries a nonzero value");

  a_draw_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW_MUL) |-> ((cmd_q == CMD_RAW) || (cmd_q == CMD_RANGED)))
    else $error("draw multiply without a draw command");

endmodule

>>> hdl/xorshift_five_word_rng_core.sv
// Raw draw: the state update step followed by the 32x32 output multiply; the result
// register is loaded once it is free, and the next command waits until then.
// Ranged draw: the draw multiply, then the restoring remainder unit takes one bit per cycle.
// Reseed: runs on the shared multiplier (two products and a write per squaring).
// Reset: all five state words are zero, the queue and result register are empty.
// Top level of the five-word xorshift random number generator.
module xorshift_five_word_rng_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [31:0]        seed_value_i,
  input  logic signed [31:0] lower_i,
  input  logic signed [31:0] upper_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               status_o
);
  import xsrng_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  item_t push_item;
  item_t head_item;

  // Classify incoming transactions
  xsrng_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .seed_value_i (seed_value_i),
    .lower_i      (lower_i),
    .upper_i      (upper_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  // Decoupling queue
  xsrng_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  // Execute and deliver results
  xsrng_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

>>> sim/xorshift_five_word_rng_core_test.sv
// Self-checking testbench for the five-word xorshift random number generator core.
module xorshift_five_word_rng_core_test;
  import xsrng_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One request offered on the input channel
  typedef struct {
    action_e     act;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
    bit          drain_first;  // sender waits until all draws are back
  } request_t;

  // One draw result as seen on the output channel
  typedef struct {
    logic [31:0] value;
    logic        status;
  } draw_result_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [1:0]         action     = ACT_IGNORE;
  logic [31:0]        seed_value = '0;
  logic signed [31:0] lower      = '0;
  logic signed [31:0] upper      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic signed [31:0] value;
  logic               status;

  request_t     queued_requests[$];
  draw_result_t awaited_draws[$];
  request_t     next_req;
  draw_result_t due;

  // Predicted generator state
  logic [63:0] rng_x = '0;
  logic [63:0] rng_y = '0;
  logic [63:0] rng_z = '0;
  logic [63:0] rng_w = '0;
  logic [63:0] rng_v = '0;

  bit in_moved        = 1'b0;
  int items_sent      = 0;
  int inputs_accepted = 0;
  int error_count     = 0;
  int hold_left       = 0;
  bit long_hold_done  = 1'b0;

  xorshift_five_word_rng_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .seed_value_i (seed_value),
    .lower_i      (lower),
    .upper_i      (upper),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_o      (value),
    .status_o     (status)
  );

  always #6 clk = ~clk;

  // Xorshift step on the predicted state, returns the raw 32-bit draw
  function automatic logic [31:0] advance_raw();
    logic signed [63:0] x_asr;
    logic [63:0]        t;
    logic [63:0]        prod;
    x_asr = rng_x;
    x_asr = x_asr >>> ShiftA;
    t = rng_x ^ x_asr;
    rng_x = rng_y;
    rng_y = rng_z;
    rng_z = rng_w;
    rng_w = rng_v;
    rng_v = rng_v ^ (rng_v << ShiftB) ^ t ^ (t << ShiftC);
    prod = {rng_y[62:0], 1'b1} * rng_v;
    return prod[31:0];
  endfunction

  // Expected result of one accepted transaction; updates the predicted state
  function automatic draw_result_t compute_draw(logic [1:0] act, logic [31:0] seed,
                                                logic [31:0] lo_bits, logic [31:0] hi_bits);
    draw_result_t res;
    logic [63:0]  s;
    longint       lo;
    longint       hi;
    longint       r;
    longint       d;
    longint       m;
    res.value  = '0;
    res.status = 1'b0;
    case (act)
      ACT_RESEED: begin
        s = (64'(seed) + 64'(SeedOffset)) % 64'(SeedModulus) + 64'd1;
        rng_x = s * 64'(SeedMult);
        rng_y = rng_x * rng_x;
        rng_z = rng_y * rng_y;
        rng_w = rng_z * rng_z;
        rng_v = rng_w * rng_w;
      end
      ACT_RAW: res.value = advance_raw();
      ACT_RANGED: begin
        lo = longint'($signed(lo_bits));
        hi = longint'($signed(hi_bits));
        if (lo < hi) begin
          r = longint'($signed(advance_raw()));
          d = hi - lo;
          // floored modulo, span is always positive
          m = r % d;
          if (m < 0) m = m + d;
          res.value = 32'(lo + m);
        end else begin
          res.status = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_request(action_e act, logic [31:0] seed, logic [31:0] lo,
                                      logic [31:0] hi, bit drain_first);
    request_t req;
    req.act         = act;
    req.seed        = seed;
    req.lo          = lo;
    req.hi          = hi;
    req.drain_first = drain_first;
    queued_requests.push_back(req);
  endfunction

  // Idle percentage per side, by test phase
  function automatic int idle_pct(bit sender);
    if (items_sent < 210) return sender ? 25 : 59;
    if (items_sent < 420) return sender ? 59 : 25;
    return 0;
  endfunction

  // Input driver: new transaction only after the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_moved) begin
      if (queued_requests.size() != 0 &&
          !(queued_requests[0].drain_first && awaited_draws.size() != 0) &&
          $urandom_range(99) >= idle_pct(1'b1)) begin
        next_req = queued_requests.pop_front();
        action     <= next_req.act;
        seed_value <= next_req.seed;
        lower      <= next_req.lo;
        upper      <= next_req.hi;
        in_valid   <= 1'b1;
        items_sent <= items_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: random per phase, plus one long hold-off to back up the core
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!long_hold_done && inputs_accepted >= 100) begin
        hold_left      <= 400;
        long_hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (rst_n) begin
      in_moved <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        awaited_draws.push_back(compute_draw(action, seed_value, lower, upper));
        inputs_accepted <= inputs_accepted + 1;
      end
      if (out_valid && !out_stall) begin
        if (awaited_draws.size() == 0) begin
          $display("%0t: result with nothing expected, got value %h status %b",
                   $time, value, status);
          error_count++;
        end else begin
          due = awaited_draws.pop_front();
          if (value !== due.value) begin
            $display("%0t: value mismatch, expected %h got %h", $time, due.value, value);
            error_count++;
          end
          if (status !== due.status) begin
            $display("%0t: status mismatch, expected %b got %b", $time, due.status, status);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int          pick;
    int          span;
    longint      lo_l;
    longint      hi_l;
    logic [31:0] r_seed;

    // draws before any reseed see an all-zero state
    add_request(ACT_RAW, '0, '0, '0, 1'b0);
    add_request(ACT_RANGED, '0, -32'sd10, 32'sd10, 1'b0);
    add_request(ACT_IGNORE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    // seed zero wraps to the top of the seed range
    add_request(ACT_RESEED, 32'h0000_0000, '0, '0, 1'b0);
    add_request(ACT_RAW, '0, '0, '0, 1'b0);
    add_request(ACT_RAW, '0, '0, '0, 1'b0);
    // widest span, unit span, spans at both ends of the range
    add_request(ACT_RANGED, '0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_request(ACT_RANGED, '0, 32'hffff_ffff, 32'h0000_0000, 1'b0);
    add_request(ACT_RANGED, '0, 32'h8000_0000, 32'h8000_0001, 1'b0);
    add_request(ACT_RANGED, '0, 32'h7fff_fffe, 32'h7fff_ffff, 1'b0);
    // lower not below upper
    add_request(ACT_RANGED, '0, 32'sd5, 32'sd5, 1'b0);
    add_request(ACT_RANGED, '0, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_request(ACT_IGNORE, 32'h5a5a_a5a5, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_request(ACT_RESEED, 32'h0000_0001, '0, '0, 1'b0);
    add_request(ACT_RAW, '0, '0, '0, 1'b0);
    add_request(ACT_RESEED, 32'hffff_ffff, '0, '0, 1'b0);
    add_request(ACT_RAW, '0, '0, '0, 1'b0);
    add_request(ACT_RESEED, 32'hffff_fffe, '0, '0, 1'b0);
    add_request(ACT_RANGED, '0, -32'sd100, -32'sd50, 1'b0);
    add_request(ACT_RESEED, 32'h8000_0000, '0, '0, 1'b0);
    add_request(ACT_RANGED, '0, 32'h0000_0000, 32'h7fff_ffff, 1'b0);
    add_request(ACT_RANGED, '0, 32'h8000_0000, 32'h0000_0000, 1'b0);

    // random part: mostly draws, some reseeds, a few ignored codes
    for (int i = 0; i < 600; i++) begin
      pick   = $urandom_range(99);
      r_seed = $urandom;
      if (pick < 4) begin
        if ($urandom_range(3) == 0) r_seed = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
        add_request(ACT_RESEED, r_seed, $urandom, $urandom, i == 150 || i == 450);
      end else if (pick < 7) begin
        add_request(ACT_IGNORE, r_seed, $urandom, $urandom, i == 150 || i == 450);
      end else if (pick < 50) begin
        add_request(ACT_RAW, r_seed, $urandom, $urandom, i == 150 || i == 450);
      end else if (pick < 75) begin
        // short span anywhere in the signed range
        span = $urandom_range(1, 16);
        hi_l = longint'($signed(32'($urandom)));
        lo_l = hi_l - span;
        if (lo_l < -64'sd2147483648) begin
          lo_l = -64'sd2147483648;
          hi_l = lo_l + span;
        end
        add_request(ACT_RANGED, r_seed, 32'(lo_l), 32'(hi_l), i == 150 || i == 450);
      end else if (pick < 80) begin
        // equal bounds
        lo_l = longint'($signed(32'($urandom)));
        add_request(ACT_RANGED, r_seed, 32'(lo_l), 32'(lo_l), i == 150 || i == 450);
      end else begin
        // unrelated bounds, about half of them inverted
        add_request(ACT_RANGED, r_seed, $urandom, $urandom, i == 150 || i == 450);
      end
    end

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    while (queued_requests.size() != 0 || in_valid || awaited_draws.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
